/* hdl/uptd_pkg.sv */
// ---------------------------------------------------------------------------
// uptd_pkg
// Shared constants and types for the unsigned to padded decimal text block.
// ---------------------------------------------------------------------------
package uptd_pkg;

    // largest buffer, terminating nul included
    localparam int BUFFER_MAX = 16;

    // input field widths
    localparam int NUM_W  = 32;
    localparam int SIZE_W = 5;
    localparam int MIN_W  = 4;
    localparam int CHAR_W = 8;

    // one decimal digit
    localparam int DIGIT_W = 4;

    // character count: holds 0 .. BUFFER_MAX-1
    localparam int LEN_W = (BUFFER_MAX > 1) ? $clog2(BUFFER_MAX) : 1;

    // width for comparing sizes, rooms and minimums, holds 0 .. 63
    localparam int CNT_W = 6;

    // divide by ten as multiply by reciprocal then shift
    localparam logic [NUM_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 35;
    localparam int PROD_W      = 2 * NUM_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    // ascii codes
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NUL  = 8'h00;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    // digits of one item, lowest order in entry 0, plus the character count
    typedef struct packed {
        logic [BUFFER_MAX-1:0][DIGIT_W-1:0] digits;
        logic [LEN_W-1:0]                   len;
    } job_t;

    // front sequencer states
    typedef enum logic [2:0] {
        FR_IDLE = 3'b001,
        FR_CONV = 3'b010,
        FR_PUSH = 3'b100
    } front_state_t;

endpackage

/* hdl/uptd_front.sv */
// ---------------------------------------------------------------------------
// uptd_front
// Accepts a word, peels off decimal digits one a cycle, applies padding and
// hands the finished job to the queue.
// ---------------------------------------------------------------------------
module uptd_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [uptd_pkg::NUM_W-1:0]      number,
    input  logic [uptd_pkg::SIZE_W-1:0]     buffer_size,
    input  logic [uptd_pkg::MIN_W-1:0]      min_digits,
    output logic                            push_valid,
    input  logic                            push_ready,
    output uptd_pkg::job_t                  push_data
);

    uptd_pkg::front_state_t state_reg, state_next;

    logic [uptd_pkg::NUM_W-1:0]   value_reg, value_next;
    logic [uptd_pkg::LEN_W-1:0]   room_reg, room_next;
    logic [uptd_pkg::LEN_W-1:0]   left_reg, left_next;
    logic [uptd_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [uptd_pkg::MIN_W-1:0]   min_reg, min_next;
    logic [uptd_pkg::BUFFER_MAX-1:0][uptd_pkg::DIGIT_W-1:0] digits_reg, digits_next;

    logic [uptd_pkg::PROD_W-1:0]  prod;
    logic [uptd_pkg::QUOT_W-1:0]  quot;
    logic [uptd_pkg::DIGIT_W-1:0] digit;
    logic [uptd_pkg::CNT_W-1:0]   size_ext;
    logic [uptd_pkg::CNT_W-1:0]   size_sat;
    logic [uptd_pkg::LEN_W-1:0]   room_in;
    logic [uptd_pkg::CNT_W-1:0]   min_ext;
    logic [uptd_pkg::CNT_W-1:0]   room_ext;
    logic [uptd_pkg::CNT_W-1:0]   len_ext;
    logic [uptd_pkg::CNT_W-1:0]   pad_len;
    logic [uptd_pkg::CNT_W-1:0]   final_len;

    // one digit: quotient by reciprocal, remainder from the low bits
    always_comb
    begin
        prod  = uptd_pkg::PROD_W'(value_reg) * uptd_pkg::PROD_W'(uptd_pkg::RECIP_TEN);
        quot  = prod[uptd_pkg::PROD_W-1:uptd_pkg::RECIP_SHIFT];
        digit = value_reg[uptd_pkg::DIGIT_W-1:0]
                - ({quot[0], 3'b000} + {quot[2:0], 1'b0});
    end

    // room from the buffer size, saturated to the largest buffer
    always_comb
    begin
        size_ext = uptd_pkg::CNT_W'(buffer_size);
        size_sat = (size_ext > uptd_pkg::CNT_W'(uptd_pkg::BUFFER_MAX))
                   ? uptd_pkg::CNT_W'(uptd_pkg::BUFFER_MAX) : size_ext;
        room_in  = (size_sat == '0) ? '0 : uptd_pkg::LEN_W'(size_sat - 1'b1);
    end

    // final count: digits, or the minimum as far as room allows
    always_comb
    begin
        min_ext   = uptd_pkg::CNT_W'(min_reg);
        room_ext  = uptd_pkg::CNT_W'(room_reg);
        len_ext   = uptd_pkg::CNT_W'(len_reg);
        pad_len   = (min_ext < room_ext) ? min_ext : room_ext;
        final_len = (len_ext > pad_len) ? len_ext : pad_len;
    end

    assign in_ready          = (state_reg == uptd_pkg::FR_IDLE);
    assign push_valid        = (state_reg == uptd_pkg::FR_PUSH);
    assign push_data.digits  = digits_reg;
    assign push_data.len     = uptd_pkg::LEN_W'(final_len);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        value_next  = value_reg;
        room_next   = room_reg;
        left_next   = left_reg;
        len_next    = len_reg;
        min_next    = min_reg;
        digits_next = digits_reg;
        case (state_reg)
            uptd_pkg::FR_IDLE:
            begin
                if (in_valid)
                begin
                    value_next  = number;
                    room_next   = room_in;
                    left_next   = room_in;
                    len_next    = '0;
                    min_next    = min_digits;
                    digits_next = '0;
                    state_next  = (room_in == '0) ? uptd_pkg::FR_PUSH : uptd_pkg::FR_CONV;
                end
            end
            uptd_pkg::FR_CONV:
            begin
                digits_next[len_reg] = digit;
                value_next           = uptd_pkg::NUM_W'(quot);
                len_next             = len_reg + 1'b1;
                left_next            = left_reg - 1'b1;
                if ((quot == '0) || (left_reg == uptd_pkg::LEN_W'(1)))
                begin
                    state_next = uptd_pkg::FR_PUSH;
                end
            end
            uptd_pkg::FR_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = uptd_pkg::FR_IDLE;
                end
            end
            default:
            begin
                state_next = uptd_pkg::FR_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= uptd_pkg::FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // working values
    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        room_reg   <= room_next;
        left_reg   <= left_next;
        len_reg    <= len_next;
        min_reg    <= min_next;
        digits_reg <= digits_next;
    end

endmodule

/* hdl/uptd_queue.sv */
// ---------------------------------------------------------------------------
// uptd_queue
// Short job queue that lets the front and the back stall on their own.
// ---------------------------------------------------------------------------
module uptd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  uptd_pkg::job_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output uptd_pkg::job_t pop_data
);

    uptd_pkg::job_t store_reg [uptd_pkg::QUEUE_DEPTH];

    logic [uptd_pkg::QP_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [uptd_pkg::QP_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [uptd_pkg::QC_W-1:0] count_reg, count_next;
    logic                      push;
    logic                      pop;

    assign push_ready = (count_reg != uptd_pkg::QC_W'(uptd_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = store_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // pointers wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == uptd_pkg::QP_W'(uptd_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == uptd_pkg::QP_W'(uptd_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/uptd_back.sv */
// ---------------------------------------------------------------------------
// uptd_back
// Takes a job from the queue and sends its characters, most significant
// digit first, then the nul word marked last, through an output register.
// ---------------------------------------------------------------------------
module uptd_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  uptd_pkg::job_t               pop_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [uptd_pkg::CHAR_W-1:0]  character,
    output logic                         last
);

    uptd_pkg::job_t               job_reg, job_next;
    logic [uptd_pkg::LEN_W-1:0]   rem_reg, rem_next;
    logic                         busy_reg, busy_next;
    logic                         out_valid_reg, out_valid_next;
    logic [uptd_pkg::CHAR_W-1:0]  char_reg, char_next;
    logic                         last_reg, last_next;
    logic                         advance;
    logic [uptd_pkg::LEN_W-1:0]   idx;

    assign pop_ready = !busy_reg;
    assign advance   = !out_valid_reg || out_ready;
    assign idx       = rem_reg - 1'b1;
    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

    // load a job when free, emit one word whenever the output moves while a job is loaded
    always_comb
    begin
        job_next       = job_reg;
        rem_next       = rem_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        if (!busy_reg)
        begin
            if (pop_valid)
            begin
                job_next  = pop_data;
                rem_next  = pop_data.len;
                busy_next = 1'b1;
            end
        end
        if (advance)
        begin
            out_valid_next = busy_reg;
            if (busy_reg)
            begin
                if (rem_reg != '0)
                begin
                    char_next = uptd_pkg::ASCII_ZERO
                                + uptd_pkg::CHAR_W'(job_reg.digits[idx]);
                    last_next = 1'b0;
                    rem_next  = rem_reg - 1'b1;
                end
                else
                begin
                    char_next = uptd_pkg::ASCII_NUL;
                    last_next = 1'b1;
                    busy_next = 1'b0;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // job and output word
    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        rem_reg  <= rem_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

/* hdl/unsigned_to_padded_decimal_text.sv */
// ---------------------------------------------------------------------------
// unsigned_to_padded_decimal_text
// Converts a 32-bit unsigned number to zero-padded decimal ascii text,
// one character a word, closed by a nul word marked last.
// ---------------------------------------------------------------------------
//
//  channel   handshake             payload
//  -------   -------------------   -------------------------------------
//  input     in_valid / in_ready   number, buffer_size, min_digits
//  output    out_valid / out_ready character, last
//
// the front takes one word, then extracts its digits (up to 10) in the
// divide-by-ten unit and hands the job to a two-deep queue; the back loads
// a job, then sends len + 1 words, one a cycle while out_ready is high,
// and takes the next job only after the nul word of the last one
// asynchronous active-low reset empties the queue and drops any output word
// a stalled output holds the back; the front keeps converting until the
// queue is full
module unsigned_to_padded_decimal_text (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [uptd_pkg::NUM_W-1:0]   number,
    input  logic [uptd_pkg::SIZE_W-1:0]  buffer_size,
    input  logic [uptd_pkg::MIN_W-1:0]   min_digits,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [uptd_pkg::CHAR_W-1:0]  character,
    output logic                         last
);

    logic           push_valid;
    logic           push_ready;
    uptd_pkg::job_t push_data;
    logic           pop_valid;
    logic           pop_ready;
    uptd_pkg::job_t pop_data;

    // digit extraction and padding
    uptd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .number      (number),
        .buffer_size (buffer_size),
        .min_digits  (min_digits),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    // job queue
    uptd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // character output
    uptd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

endmodule

/* hdl/uptd_checker.sv */
// ---------------------------------------------------------------------------
// uptd_checker
// Port-level checks on the decimal text block, bound to the top level.
// ---------------------------------------------------------------------------
module uptd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [uptd_pkg::CHAR_W-1:0]  character,
    input logic                         last
);

    // a stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
        else $error("output word changed while stalled");

    // the nul word closes the text
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> character == uptd_pkg::ASCII_NUL)
        else $error("last word is not nul");

    // every other word is a decimal digit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> character >= uptd_pkg::ASCII_ZERO
                            && character <= uptd_pkg::ASCII_ZERO + 8'd9)
        else $error("text word is not a digit");

    // the front is not ready in the cycle after taking a word
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready straight after an accepted word");

endmodule

bind unsigned_to_padded_decimal_text uptd_checker u_uptd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last)
);
